@@ design/lfpd_pkg.sv @@
// Package for the line-follow PD steering block.
// Holds the field types, register indexes, reset values and stage payload structs.
// Used by every other file of the design; depends on nothing.
package lfpd_pkg;

  localparam int FRAC_BITS = 12;
  localparam int REG_COUNT = 5;
  localparam int ADDR_W    = 5;

  typedef logic [12:0]        pos_t;
  typedef logic [15:0]        gain_t;
  typedef logic [7:0]         speed_t;
  typedef logic signed [13:0] err_t;
  typedef logic signed [14:0] diff_t;
  typedef logic signed [30:0] prod_t;
  typedef logic signed [31:0] sum_t;
  typedef logic signed [19:0] corr_t;
  typedef logic signed [20:0] wheel_t;
  typedef logic signed [8:0]  drive_t;

  typedef enum logic [2:0] {
    REG_SETPOINT  = 3'd0,
    REG_KP_GAIN   = 3'd1,
    REG_KD_GAIN   = 3'd2,
    REG_SPIN_THR  = 3'd3,
    REG_FULL_SPD  = 3'd4
  } reg_idx_t;

  localparam pos_t   RST_SETPOINT = 13'd2500;
  localparam gain_t  RST_KP_GAIN  = 16'd410;
  localparam gain_t  RST_KD_GAIN  = 16'd9216;
  localparam pos_t   RST_SPIN_THR = 13'd2300;
  localparam speed_t RST_FULL_SPD = 8'd254;

  typedef enum logic [1:0] {
    SPIN_NONE  = 2'd0,
    SPIN_LEFT  = 2'd1,
    SPIN_RIGHT = 2'd2
  } spin_t;

  typedef struct packed {
    pos_t   setpoint;
    gain_t  kp_gain;
    gain_t  kd_gain;
    pos_t   spin_threshold;
    speed_t full_speed;
  } cfg_t;

  // Payload handed from the error stage to the multiply stage.
  typedef struct packed {
    err_t  err;
    diff_t diff;
  } err_stage_t;

  // Payload handed from the multiply stage to the drive stage.
  typedef struct packed {
    prod_t p_term;
    prod_t d_term;
    spin_t spin;
  } prod_stage_t;

endpackage

@@ design/lfpd_if.sv @@
// Channel interfaces for the line-follow PD steering block.
// One interface for the position samples, one for the wheel drive results.
// Depends on lfpd_pkg.
interface lfpd_in_if;
  logic             valid;
  logic             ready;
  lfpd_pkg::pos_t   position;

  modport source (output valid, output position, input ready);
  modport sink   (input valid, input position, output ready);
endinterface

interface lfpd_out_if;
  logic             valid;
  logic             ready;
  lfpd_pkg::drive_t left_drive;
  lfpd_pkg::drive_t right_drive;

  modport source (output valid, output left_drive, output right_drive, input ready);
  modport sink   (input valid, input left_drive, input right_drive, output ready);
endinterface

@@ design/line_follow_pd_steering.sv @@
// Line-follow PD steering for a differential-drive robot.
// Depends on lfpd_pkg, the channel interfaces and the lfpd_* stage modules.
//
// Usage: position samples arrive on in_ch (valid/ready); each accepted
// sample yields exactly one left/right wheel drive pair on out_ch. The
// setpoint, gains, spin threshold and full speed sit behind a small APB
// slave (byte addresses 0, 4, 8, 12, 16); write them only while idle.
//
// out_ch.valid comes from the last of the stage registers: one register
// for the error, one for the two gain products, and one for the clamped
// wheel drive. Throughput is one sample per cycle while out_ch.ready is
// held high; the two multipliers in the middle stage set the clock period.
//
// Reset loads the register defaults, clears the previous error and
// empties the pipeline. When the receiver holds off ready, each stage
// keeps its item, and the input keeps taking samples until all three
// stages are full, then in_ch.ready drops until a result transfer.
module line_follow_pd_steering (
  input  logic                        clk,
  input  logic                        rst_n,
  lfpd_in_if.sink                     in_ch,
  lfpd_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfpd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lfpd_pkg::cfg_t        cfg;
  logic                  err_valid;
  logic                  err_ready;
  lfpd_pkg::err_stage_t  err_data;
  logic                  prod_valid;
  logic                  prod_ready;
  lfpd_pkg::prod_stage_t prod_data;

  lfpd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfpd_err u_err (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .cfg   (cfg),
    .valid (err_valid),
    .ready (err_ready),
    .data  (err_data)
  );

  lfpd_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (err_valid),
    .in_ready (err_ready),
    .in_data  (err_data),
    .valid    (prod_valid),
    .ready    (prod_ready),
    .data     (prod_data)
  );

  lfpd_drv u_drv (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (prod_valid),
    .in_ready (prod_ready),
    .in_data  (prod_data),
    .out_ch   (out_ch)
  );

endmodule

@@ design/lfpd_cfg.sv @@
// Configuration register file with an APB-style slave port.
// Provides the setpoint, gains, spin threshold and full speed as one struct.
// Depends on lfpd_pkg.
module lfpd_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lfpd_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output lfpd_pkg::cfg_t            cfg
);

  lfpd_pkg::cfg_t   cfg_r;
  lfpd_pkg::cfg_t   cfg_nxt;
  lfpd_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = lfpd_pkg::reg_idx_t'(paddr[lfpd_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        lfpd_pkg::REG_SETPOINT: cfg_nxt.setpoint       = pwdata[12:0];
        lfpd_pkg::REG_KP_GAIN:  cfg_nxt.kp_gain        = pwdata[15:0];
        lfpd_pkg::REG_KD_GAIN:  cfg_nxt.kd_gain        = pwdata[15:0];
        lfpd_pkg::REG_SPIN_THR: cfg_nxt.spin_threshold = pwdata[12:0];
        lfpd_pkg::REG_FULL_SPD: cfg_nxt.full_speed     = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lfpd_pkg::REG_SETPOINT: prdata = {19'd0, cfg_r.setpoint};
      lfpd_pkg::REG_KP_GAIN:  prdata = {16'd0, cfg_r.kp_gain};
      lfpd_pkg::REG_KD_GAIN:  prdata = {16'd0, cfg_r.kd_gain};
      lfpd_pkg::REG_SPIN_THR: prdata = {19'd0, cfg_r.spin_threshold};
      lfpd_pkg::REG_FULL_SPD: prdata = {24'd0, cfg_r.full_speed};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.setpoint       <= lfpd_pkg::RST_SETPOINT;
      cfg_r.kp_gain        <= lfpd_pkg::RST_KP_GAIN;
      cfg_r.kd_gain        <= lfpd_pkg::RST_KD_GAIN;
      cfg_r.spin_threshold <= lfpd_pkg::RST_SPIN_THR;
      cfg_r.full_speed     <= lfpd_pkg::RST_FULL_SPD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ design/lfpd_err.sv @@
// Error stage: takes a position sample, forms the error and its difference
// from the previous error, and keeps the previous error. Depends on lfpd_pkg.
module lfpd_err (
  input  logic                 clk,
  input  logic                 rst_n,
  lfpd_in_if.sink              in_ch,
  input  lfpd_pkg::cfg_t       cfg,
  output logic                 valid,
  input  logic                 ready,
  output lfpd_pkg::err_stage_t data
);

  logic                 valid_r;
  lfpd_pkg::err_stage_t data_r;
  lfpd_pkg::err_stage_t data_nxt;
  lfpd_pkg::err_t       last_error_r;
  logic                 take;

  assign in_ch.ready = !valid_r || ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign valid       = valid_r;
  assign data        = data_r;

  always_comb begin
    data_nxt.err  = lfpd_pkg::err_t'({1'b0, in_ch.position}) -
                    lfpd_pkg::err_t'({1'b0, cfg.setpoint});
    data_nxt.diff = lfpd_pkg::diff_t'(data_nxt.err) - lfpd_pkg::diff_t'(last_error_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      last_error_r <= '0;
    end else begin
      if (in_ch.ready) begin
        valid_r <= in_ch.valid;
      end
      if (take) begin
        last_error_r <= data_nxt.err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ design/lfpd_mul.sv @@
// Multiply stage: forms the proportional and derivative terms and decides
// whether the error calls for a spin in place. Depends on lfpd_pkg.
module lfpd_mul (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfpd_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lfpd_pkg::err_stage_t  in_data,
  output logic                  valid,
  input  logic                  ready,
  output lfpd_pkg::prod_stage_t data
);

  logic                  valid_r;
  lfpd_pkg::prod_stage_t data_r;
  lfpd_pkg::prod_stage_t data_nxt;
  lfpd_pkg::prod_t       kp_x;
  lfpd_pkg::prod_t       kd_x;
  logic signed [14:0]    thr_x;
  logic signed [14:0]    err_x;
  logic                  take;

  assign in_ready = !valid_r || ready;
  assign take     = in_valid && in_ready;
  assign valid    = valid_r;
  assign data     = data_r;

  always_comb begin
    // Gains are unsigned; zero-extend so the products stay signed.
    kp_x = lfpd_pkg::prod_t'({1'b0, cfg.kp_gain});
    kd_x = lfpd_pkg::prod_t'({1'b0, cfg.kd_gain});
    data_nxt.p_term = kp_x * lfpd_pkg::prod_t'(in_data.err);
    data_nxt.d_term = kd_x * lfpd_pkg::prod_t'(in_data.diff);
    thr_x = $signed({2'b00, cfg.spin_threshold});
    err_x = 15'(in_data.err);
    if (err_x < -thr_x) begin
      data_nxt.spin = lfpd_pkg::SPIN_LEFT;
    end else if (err_x > thr_x) begin
      data_nxt.spin = lfpd_pkg::SPIN_RIGHT;
    end else begin
      data_nxt.spin = lfpd_pkg::SPIN_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= data_nxt;
    end
  end

endmodule

@@ design/lfpd_drv.sv @@
// Drive stage: sums the terms, scales the correction back to integer with truncation
// toward zero, and clamps each wheel into the result register, or drives full speed both ways for a spin.
// Depends on lfpd_pkg and the result channel interface.
module lfpd_drv (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfpd_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lfpd_pkg::prod_stage_t in_data,
  lfpd_out_if.source            out_ch
);

  localparam lfpd_pkg::sum_t ROUND_ADJ = lfpd_pkg::sum_t'((1 << lfpd_pkg::FRAC_BITS) - 1);

  logic             valid_r;
  lfpd_pkg::drive_t left_r;
  lfpd_pkg::drive_t right_r;
  lfpd_pkg::drive_t left_nxt;
  lfpd_pkg::drive_t right_nxt;
  lfpd_pkg::sum_t   sum;
  lfpd_pkg::sum_t   sum_adj;
  lfpd_pkg::corr_t  corr;
  lfpd_pkg::wheel_t full_w;
  lfpd_pkg::wheel_t left_w;
  lfpd_pkg::wheel_t right_w;
  lfpd_pkg::drive_t full_d;
  logic             take;

  assign in_ready       = !valid_r || out_ch.ready;
  assign take           = in_valid && in_ready;
  assign out_ch.valid   = valid_r;
  assign out_ch.left_drive  = left_r;
  assign out_ch.right_drive = right_r;

  always_comb begin
    sum = lfpd_pkg::sum_t'(in_data.p_term) + lfpd_pkg::sum_t'(in_data.d_term);
    // Adding 2^12-1 before the arithmetic shift makes negative sums round toward zero.
    sum_adj = sum[31] ? sum + ROUND_ADJ : sum;
    corr    = sum_adj[31:lfpd_pkg::FRAC_BITS];
    full_w  = lfpd_pkg::wheel_t'({1'b0, cfg.full_speed});
    full_d  = lfpd_pkg::drive_t'({1'b0, cfg.full_speed});
    left_w  = full_w - lfpd_pkg::wheel_t'(corr);
    right_w = full_w + lfpd_pkg::wheel_t'(corr);
    if (left_w > full_w) begin
      left_w = full_w;
    end
    if (left_w < 21'sd1) begin
      left_w = 21'sd1;
    end
    if (right_w > full_w) begin
      right_w = full_w;
    end
    if (right_w < 21'sd1) begin
      right_w = 21'sd1;
    end
    case (in_data.spin)
      lfpd_pkg::SPIN_LEFT: begin
        left_nxt  = -full_d;
        right_nxt = full_d;
      end
      lfpd_pkg::SPIN_RIGHT: begin
        left_nxt  = full_d;
        right_nxt = -full_d;
      end
      default: begin
        left_nxt  = left_w[8:0];
        right_nxt = right_w[8:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

@@ bench/tb_top.sv @@
// Self-checking bench for line_follow_pd_steering: feeds position samples,
// programs the APB registers between phases and checks every wheel drive pair.
// Depends on lfpd_pkg, the lfpd channel interfaces and the block itself.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lfpd_pkg::*;

  typedef struct packed {
    drive_t left;
    drive_t right;
  } wheel_pair_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  lfpd_in_if  in_ch ();
  lfpd_out_if out_ch ();

  line_follow_pd_steering DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block's registers and its previous error.
  cfg_t        shadow_cfg;
  err_t        prev_err;
  pos_t        position_q[$];
  wheel_pair_t drive_exp_q[$];
  int          err_cnt;

  int unsigned in_xfer_cnt;
  int unsigned drv_seen_cnt;
  int          burst_left;
  int          gap_left;

  int unsigned hold_req_cnt;
  int unsigned hold_done_cnt;
  int          hold_left;
  int          rx_mode;
  int          rx_win;
  int unsigned rx_phase;

  function automatic wheel_pair_t steer_predict(pos_t p);
    int          e;
    int          d;
    longint      acc;
    longint      corr;
    longint      top;
    longint      thr;
    longint      l;
    longint      r;
    wheel_pair_t w;
    e    = int'(p) - int'(shadow_cfg.setpoint);
    d    = e - int'(prev_err);
    acc  = longint'(shadow_cfg.kp_gain) * e + longint'(shadow_cfg.kd_gain) * d;
    // Integer division truncates toward zero, which is what the block does.
    corr = acc / (longint'(1) << FRAC_BITS);
    top  = longint'(shadow_cfg.full_speed);
    thr  = longint'(shadow_cfg.spin_threshold);
    prev_err = err_t'(e);
    if (e < -thr) begin
      l = -top;
      r = top;
    end else if (e > thr) begin
      l = top;
      r = -top;
    end else begin
      // Upper clamp first, then the lower one, so a zero full speed gives 1.
      l = top - corr;
      r = top + corr;
      if (l > top) l = top;
      if (l < 1) l = 1;
      if (r > top) r = top;
      if (r < 1) r = 1;
    end
    w.left  = l[8:0];
    w.right = r[8:0];
    return w;
  endfunction

  // Input side: prediction at the transfer, driving at the falling edge.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      drive_exp_q.push_back(steer_predict(in_ch.position));
      in_xfer_cnt = in_xfer_cnt + 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_xfer_cnt != drv_seen_cnt)) begin
      drv_seen_cnt = in_xfer_cnt;
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (position_q.size() > 0) begin
        in_ch.valid    <= 1'b1;
        in_ch.position <= position_q.pop_front();
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(30, 80);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20)
                                                    : $urandom_range(0, 5);
          end
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side: the receiver stalls on windows of random modes, plus long holds
  // on request from the stimulus.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_req_cnt != hold_done_cnt) begin
        hold_done_cnt = hold_req_cnt;
        hold_left     = 60;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_win == 0) begin
          rx_mode = $urandom_range(0, 3);
          rx_win  = $urandom_range(16, 96);
        end
        rx_win   = rx_win - 1;
        rx_phase = rx_phase + 1;
        case (rx_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= (rx_phase % 3 == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    wheel_pair_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_exp_q.size() == 0) begin
        $display("%0t: unexpected result left=%0d right=%0d", $time,
                 out_ch.left_drive, out_ch.right_drive);
        err_cnt = err_cnt + 1;
      end else begin
        want = drive_exp_q.pop_front();
        if (out_ch.left_drive !== want.left) begin
          $display("%0t: left_drive expected %0d actual %0d", $time,
                   want.left, out_ch.left_drive);
          err_cnt = err_cnt + 1;
        end
        if (out_ch.right_drive !== want.right) begin
          $display("%0t: right_drive expected %0d actual %0d", $time,
                   want.right, out_ch.right_drive);
          err_cnt = err_cnt + 1;
        end
      end
    end
  end

  task automatic reg_write(int idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx * 4);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (reg_idx_t'(idx))
      REG_SETPOINT: shadow_cfg.setpoint       = value[12:0];
      REG_KP_GAIN:  shadow_cfg.kp_gain        = value[15:0];
      REG_KD_GAIN:  shadow_cfg.kd_gain        = value[15:0];
      REG_SPIN_THR: shadow_cfg.spin_threshold = value[12:0];
      REG_FULL_SPD: shadow_cfg.full_speed     = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read_check(int idx);
    logic [31:0] want;
    case (reg_idx_t'(idx))
      REG_SETPOINT: want = 32'(shadow_cfg.setpoint);
      REG_KP_GAIN:  want = 32'(shadow_cfg.kp_gain);
      REG_KD_GAIN:  want = 32'(shadow_cfg.kd_gain);
      REG_SPIN_THR: want = 32'(shadow_cfg.spin_threshold);
      default:      want = 32'(shadow_cfg.full_speed);
    endcase
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'(idx * 4);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %0h actual %0h", $time, idx, want, prdata);
      err_cnt = err_cnt + 1;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the value, with random upper bits above the field on some writes.
  task automatic reg_write_field(int idx, int unsigned value, int field_w);
    logic [31:0] mask;
    logic [31:0] word;
    mask = (32'h1 << field_w) - 1;
    word = 32'(value) & mask;
    if ($urandom_range(0, 2) == 0) word = word | ($urandom & ~mask);
    reg_write(idx, word);
  endtask

  task automatic wait_drained();
    while (position_q.size() != 0 || in_ch.valid || drive_exp_q.size() != 0)
      @(posedge clk);
    // Pipeline is three stages deep.
    repeat (4) @(posedge clk);
  endtask

  task automatic check_all_regs();
    for (int i = 0; i < REG_COUNT; i++) reg_read_check(i);
  endtask

  function automatic int unsigned pick_edge(int unsigned hi, int unsigned mid_lo,
                                            int unsigned mid_hi);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return hi;
      default: return $urandom_range(mid_lo, mid_hi);
    endcase
  endfunction

  task automatic randomize_config();
    reg_write_field(REG_SETPOINT, pick_edge(8191, 800, 7400), 13);
    reg_write_field(REG_KP_GAIN, pick_edge(65535, 0, ($urandom_range(0, 1) != 0) ? 4095 : 65535),
                    16);
    reg_write_field(REG_KD_GAIN, pick_edge(65535, 0, ($urandom_range(0, 1) != 0) ? 8191 : 65535),
                    16);
    reg_write_field(REG_SPIN_THR, pick_edge(8191, 50, 4000), 13);
    reg_write_field(REG_FULL_SPD, ($urandom_range(0, 4) == 0) ? 1 : pick_edge(255, 2, 254), 8);
  endtask

  // Mostly samples inside the steering band, where the clamps and the
  // derivative term matter, with the band edges and the full range mixed in.
  function automatic pos_t pick_position();
    int c;
    int t;
    c = int'(shadow_cfg.setpoint);
    t = int'(shadow_cfg.spin_threshold);
    case ($urandom_range(0, 9))
      0, 1, 2: c = $urandom_range(0, 8191);
      3: c = ($urandom_range(0, 1) != 0) ? c + t + $urandom_range(0, 1)
                                        : c - t - $urandom_range(0, 1);
      default: c = c + $urandom_range(0, 2 * t + 4) - t - 2;
    endcase
    if (c < 0) c = 0;
    if (c > 8191) c = 8191;
    return pos_t'(c);
  endfunction

  initial begin
    err_cnt       = 0;
    in_xfer_cnt   = 0;
    drv_seen_cnt  = 0;
    burst_left    = 1;
    gap_left      = 0;
    hold_req_cnt  = 0;
    hold_done_cnt = 0;
    hold_left     = 0;
    rx_mode       = 0;
    rx_win        = 0;
    rx_phase      = 0;
    shadow_cfg.setpoint       = RST_SETPOINT;
    shadow_cfg.kp_gain        = RST_KP_GAIN;
    shadow_cfg.kd_gain        = RST_KD_GAIN;
    shadow_cfg.spin_threshold = RST_SPIN_THR;
    shadow_cfg.full_speed     = RST_FULL_SPD;
    prev_err = '0;
    rst_n    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_ch.valid     = 1'b0;
    in_ch.position  = '0;
    out_ch.ready    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset values: zero error, both threshold edges, spins at the field limits.
    check_all_regs();
    foreach (position_q[i]) ;
    position_q = '{13'd2500, 13'd4800, 13'd4801, 13'd200, 13'd199, 13'd0, 13'd8191,
                   13'd2600, 13'd2400, 13'd3700, 13'd2500};
    wait_drained();

    // Zero full speed, written with garbage in the upper bits.
    reg_write(REG_FULL_SPD, 32'hFFFF_FF00);
    position_q = '{13'd2500, 13'd2600, 13'd8191, 13'd0};
    wait_drained();

    // Largest setpoint, gains and threshold: error reaches the threshold exactly at position 0, zero at 8191.
    reg_write(REG_SETPOINT, 32'hABCD_FFFF);
    reg_write(REG_KP_GAIN, 32'h0000_FFFF);
    reg_write(REG_KD_GAIN, 32'h1234_FFFF);
    reg_write(REG_SPIN_THR, 32'h0000_1FFF);
    reg_write(REG_FULL_SPD, 32'h0000_00FF);
    check_all_regs();
    position_q = '{13'd0, 13'd8191, 13'd0};
    wait_drained();

    // Zero setpoint, gains and threshold; writes to unused addresses are ignored.
    reg_write(REG_SETPOINT, 32'h0000_0000);
    reg_write(REG_KP_GAIN, 32'h0000_0000);
    reg_write(REG_KD_GAIN, 32'hFFFF_0000);
    reg_write(REG_SPIN_THR, 32'h0000_0000);
    reg_write(REG_FULL_SPD, 32'h0000_0001);
    for (int i = REG_COUNT; i < 8; i++) reg_write(i, $urandom);
    check_all_regs();
    position_q = '{13'd0, 13'd1, 13'd0};
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      randomize_config();
      check_all_regs();
      if (ph == 2 || ph == 7) hold_req_cnt = hold_req_cnt + 1;
      for (int k = 0; k < 68; k++) begin
        if (k > 0 && $urandom_range(0, 15) == 0)
          position_q.push_back(position_q[$]);
        else
          position_q.push_back(pick_position());
      end
      wait_drained();
    end

    if (drive_exp_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, drive_exp_q.size());
      err_cnt = err_cnt + 1;
    end
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
design/lfpd_pkg.sv
design/lfpd_if.sv
design/lfpd_cfg.sv
design/lfpd_err.sv
design/lfpd_mul.sv
design/lfpd_drv.sv
design/line_follow_pd_steering.sv
bench/tb_top.sv
